[sv/ppf_pkg.sv]
package ppf_pkg;

  localparam int DEF_MAX_POINTS = 256;
  localparam int DEF_FRAC_BITS  = 16;

  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] ACC_MAX = 32'hFFFF_FFFF;

  // stream payload widths
  localparam int S_TDATA_W = 224;
  localparam int M_TDATA_W = 136;
  localparam int M_TUSER_W = 3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  // request kinds
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LD_WRITE,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_LD_DONE,
    OP_FULL,
    OP_EMPTY,
    OP_ADVANCE,
    OP_RD_LEN,
    OP_WALK,
    OP_RD_A,
    OP_GET_B,
    OP_LMUL,
    OP_DINIT,
    OP_DSTEP,
    OP_LFIN,
    OP_THSQ,
    OP_JUDGE,
    OP_RD_END,
    OP_END,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       sq_first;  // clear sum of squares
    logic       sq_mul;    // square this axis
    logic       sq_acc;    // add previous product
    logic       sq_jump;   // deltas against last position
  } cmd_t;

  typedef struct packed {
    logic func;
    logic full;
    logic empty;
    logic more_seg;
    logic reached;
    logic out_free;
  } sts_t;

  // midpoint rounded toward minus infinity
  function automatic logic signed [31:0] mid32(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    logic signed [32:0] s;
    s = 33'(x) + 33'(y);
    return s[32:1];
  endfunction

endpackage

[sv/ppf_ram.sv]
module ppf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ppf_dp.sv]
module ppf_dp #(
  parameter int MAX_POINTS = ppf_pkg::DEF_MAX_POINTS
) (
  input  logic                clk,
  input  logic                rst,
  input  ppf_pkg::cmd_t       cmd,
  output ppf_pkg::sts_t       sts,
  input  logic                in_func,
  input  logic signed [31:0]  in_left [3],
  input  logic signed [31:0]  in_right [3],
  input  logic [30:0]         in_step,
  input  logic [30:0]         thresh,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [31:0]  out_pos [3],
  output logic                out_smoothed,
  output logic [7:0]          out_seg,
  output logic [30:0]         out_trav,
  output logic [1:0]          out_status
);
  import ppf_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = IW + 1;

  // request and path state
  logic               func_q;
  logic [30:0]        step_q;
  logic signed [31:0] c [3];
  logic signed [31:0] prev [3];
  logic signed [31:0] last [3];
  logic signed [31:0] a [3];
  logic signed [31:0] b [3];
  logic signed [31:0] p [3];
  logic [CW-1:0]      count;
  logic [IW-1:0]      seg;
  logic [30:0]        total, trav, len_q, num_q;
  logic [31:0]        acc;

  // arithmetic units
  logic [63:0] prod, ss, rad, root, sbit;
  logic        big;
  logic [31:0] rem;
  logic [32:0] dq;

  // pending result
  logic signed [31:0] res_p [3];
  logic               res_sm;
  logic [7:0]         res_seg;
  logic [30:0]        res_trav;
  logic [1:0]         res_st;

  // memories
  logic          ctr_we, len_we;
  logic [IW-1:0] ctr_waddr, ctr_raddr, len_waddr, len_raddr;
  logic [95:0]   ctr_rdata;
  logic [30:0]   len_wdata, len_rdata;

  logic [CW-1:0] seg_ext, seg_inc, last_idx;
  assign seg_ext  = CW'(seg);
  assign seg_inc  = seg_ext + CW'(1);
  assign last_idx = count - CW'(1);

  assign ctr_we    = (cmd.op == OP_LD_WRITE);
  assign ctr_waddr = count[IW-1:0];
  assign len_waddr = last_idx[IW-1:0];
  assign len_raddr = seg;

  always_comb begin
    unique case (cmd.op)
      OP_RD_A:   ctr_raddr = seg_inc[IW-1:0];
      OP_RD_END: ctr_raddr = last_idx[IW-1:0];
      default:   ctr_raddr = seg;
    endcase
  end

  ppf_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata ({c[2], c[1], c[0]}),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  ppf_ram #(.WIDTH(31), .DEPTH(MAX_POINTS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  // squared deltas, center vs previous center or position vs last
  logic signed [32:0] dlt;
  logic [32:0]        dmag;
  logic               dbig;
  always_comb begin
    if (cmd.sq_jump) begin
      dlt = 33'(p[cmd.axis]) - 33'(last[cmd.axis]);
    end else begin
      dlt = 33'(c[cmd.axis]) - 33'(prev[cmd.axis]);
    end
    dmag = dlt[32] ? 33'(-dlt) : 33'(dlt);
    dbig = |dmag[32:31];
  end

  // interpolation terms for the current axis
  logic signed [32:0] ld, lsum;
  logic [32:0]        lmag;
  logic               ltriv;
  always_comb begin
    ld    = 33'(b[cmd.axis]) - 33'(a[cmd.axis]);
    lmag  = ld[32] ? 33'(-ld) : 33'(ld);
    ltriv = (len_q == '0) || (num_q == '0);
    lsum  = ld[32] ? 33'(a[cmd.axis]) - signed'(dq) : 33'(a[cmd.axis]) + signed'(dq);
  end

  // shared multiplier
  logic [32:0] mul_a;
  logic [30:0] mul_b;
  logic [63:0] mul_p;
  always_comb begin
    unique case (cmd.op)
      OP_LMUL: begin
        mul_a = lmag;
        mul_b = num_q;
      end
      OP_THSQ: begin
        mul_a = {2'b00, thresh};
        mul_b = thresh;
      end
      default: begin
        mul_a = dmag;
        mul_b = dmag[30:0];
      end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // square root step
  logic [63:0] sq_try;
  assign sq_try = root + sbit;

  // division step
  logic [32:0] dv_t;
  logic        dv_ge;
  assign dv_t  = {rem, dq[32]};
  assign dv_ge = dv_t >= {2'b00, len_q};

  // load: segment length and running total
  logic [30:0] seg_len;
  logic [31:0] tot_sum;
  assign seg_len   = (big || (root > 64'(LEN_MAX))) ? LEN_MAX : root[30:0];
  assign tot_sum   = 32'(total) + 32'(seg_len);
  assign len_we    = (cmd.op == OP_LD_DONE) && (count != '0);
  assign len_wdata = seg_len;

  // advance: step with wrap
  logic [31:0] adv_sum;
  logic [30:0] adv_sat;
  assign adv_sum = 32'(trav) + 32'(step_q);
  assign adv_sat = adv_sum[31] ? LEN_MAX : adv_sum[30:0];

  // walk
  logic [32:0] walk_sum;
  logic [31:0] num_raw;
  assign walk_sum = 33'(acc) + 33'(len_rdata);
  assign num_raw  = (32'(trav) > acc) ? 32'(trav) - acc : '0;

  logic smooth;
  assign smooth = big || (ss > prod);

  assign sts.func     = func_q;
  assign sts.full     = (count == CW'(MAX_POINTS));
  assign sts.empty    = (count == '0);
  assign sts.more_seg = (seg_inc < count);
  assign sts.reached  = (walk_sum >= 33'(trav));
  assign sts.out_free = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      trav      <= '0;
      seg       <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        last[i] <= '0;
      end
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_LD_DONE: begin
          count <= count + CW'(1);
          if (count == '0) begin
            last <= c;
          end else begin
            total <= tot_sum[31] ? LEN_MAX : tot_sum[30:0];
          end
        end
        OP_ADVANCE: begin
          if (adv_sat > total) begin
            trav <= adv_sat - total;
            seg  <= '0;
            acc  <= '0;
          end else begin
            trav <= adv_sat;
          end
        end
        OP_WALK: begin
          if (!sts.reached) begin
            acc <= walk_sum[32] ? ACC_MAX : walk_sum[31:0];
            seg <= seg + IW'(1);
          end
        end
        OP_JUDGE: begin
          for (int i = 0; i < 3; i++) begin
            last[i] <= smooth ? mid32(last[i], p[i]) : p[i];
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        func_q <= in_func;
        step_q <= in_step;
        for (int i = 0; i < 3; i++) begin
          c[i] <= mid32(in_left[i], in_right[i]);
        end
      end
      OP_SQ: begin
        ss <= (cmd.sq_first ? 64'd0 : ss) + (cmd.sq_acc ? prod : 64'd0);
        if (cmd.sq_mul) begin
          prod <= mul_p;
          big  <= (cmd.sq_first ? 1'b0 : big) | dbig;
        end
      end
      OP_SQRT_INIT: begin
        rad  <= ss;
        root <= '0;
        sbit <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (rad >= sq_try) begin
          rad  <= rad - sq_try;
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
      end
      OP_LD_DONE: begin
        prev     <= c;
        res_p    <= c;
        res_sm   <= 1'b0;
        res_seg  <= 8'(count);
        res_trav <= trav;
        res_st   <= ST_OK;
      end
      OP_FULL: begin
        for (int i = 0; i < 3; i++) begin
          res_p[i] <= '0;
        end
        res_sm   <= 1'b0;
        res_seg  <= '0;
        res_trav <= trav;
        res_st   <= ST_FULL;
      end
      OP_EMPTY: begin
        for (int i = 0; i < 3; i++) begin
          res_p[i] <= '0;
        end
        res_sm   <= 1'b0;
        res_seg  <= 8'(seg);
        res_trav <= trav;
        res_st   <= ST_EMPTY;
      end
      OP_WALK: begin
        len_q <= len_rdata;
        num_q <= (num_raw > 32'(len_rdata)) ? len_rdata : num_raw[30:0];
      end
      OP_RD_A: begin
        for (int i = 0; i < 3; i++) begin
          a[i] <= ctr_rdata[32*i +: 32];
        end
      end
      OP_GET_B: begin
        for (int i = 0; i < 3; i++) begin
          b[i] <= ctr_rdata[32*i +: 32];
        end
      end
      OP_LMUL: begin
        prod <= mul_p;
      end
      OP_DINIT: begin
        rem <= {1'b0, prod[63:33]};
        dq  <= prod[32:0];
      end
      OP_DSTEP: begin
        rem <= dv_ge ? 32'(dv_t - {2'b00, len_q}) : dv_t[31:0];
        dq  <= {dq[31:0], dv_ge};
      end
      OP_LFIN: begin
        p[cmd.axis] <= ltriv ? a[cmd.axis] : lsum[31:0];
      end
      OP_THSQ: begin
        prod <= mul_p;
      end
      OP_JUDGE: begin
        for (int i = 0; i < 3; i++) begin
          res_p[i] <= smooth ? mid32(last[i], p[i]) : p[i];
        end
        res_sm   <= smooth;
        res_seg  <= 8'(seg);
        res_trav <= trav;
        res_st   <= ST_OK;
      end
      OP_END: begin
        for (int i = 0; i < 3; i++) begin
          res_p[i] <= ctr_rdata[32*i +: 32];
        end
        res_sm   <= 1'b0;
        res_seg  <= 8'(seg);
        res_trav <= trav;
        res_st   <= ST_PAST_END;
      end
      OP_EMIT: begin
        out_pos      <= res_p;
        out_smoothed <= res_sm;
        out_seg      <= res_seg;
        out_trav     <= res_trav;
        out_status   <= res_st;
      end
      default: ;
    endcase
  end

endmodule

[sv/ppf_ctrl.sv]
module ppf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ppf_pkg::sts_t  sts,
  output ppf_pkg::cmd_t  cmd
);
  import ppf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_LD_WR, S_LD_SQ, S_SQRT_INIT, S_SQRT, S_LD_DONE,
    S_FULL, S_EMPTY, S_ADV, S_WALK_RD, S_WALK_CHK, S_RD_B, S_GET_B,
    S_LMUL, S_DINIT, S_DIV, S_LFIN, S_JSQ, S_TH, S_JUDGE, S_END, S_EMIT
  } state_t;

  state_t      state, state_next;
  logic [5:0]  cnt, cnt_next;
  logic [1:0]  lax, lax_next;

  assign in_ready = (state == S_IDLE);

  // next state and command
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    lax_next     = lax;
    cmd          = '0;
    cmd.op       = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.func == FUNC_LOAD) begin
          state_next = sts.full ? S_FULL : S_LD_WR;
        end else begin
          state_next = sts.empty ? S_EMPTY : S_ADV;
        end
      end
      S_LD_WR: begin
        cmd.op     = OP_LD_WRITE;
        cnt_next   = '0;
        state_next = sts.empty ? S_LD_DONE : S_LD_SQ;
      end
      S_LD_SQ, S_JSQ: begin
        cmd.op       = OP_SQ;
        cmd.axis     = (cnt == 6'd3) ? 2'd0 : cnt[1:0];
        cmd.sq_first = (cnt == 6'd0);
        cmd.sq_mul   = (cnt != 6'd3);
        cmd.sq_acc   = (cnt != 6'd0);
        cmd.sq_jump  = (state == S_JSQ);
        cnt_next     = cnt + 6'd1;
        if (cnt == 6'd3) begin
          state_next = (state == S_JSQ) ? S_TH : S_SQRT_INIT;
        end
      end
      S_SQRT_INIT: begin
        cmd.op     = OP_SQRT_INIT;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op   = OP_SQRT_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd31) begin
          state_next = S_LD_DONE;
        end
      end
      S_LD_DONE: begin
        cmd.op     = OP_LD_DONE;
        state_next = S_EMIT;
      end
      S_FULL: begin
        cmd.op     = OP_FULL;
        state_next = S_EMIT;
      end
      S_EMPTY: begin
        cmd.op     = OP_EMPTY;
        state_next = S_EMIT;
      end
      S_ADV: begin
        cmd.op     = OP_ADVANCE;
        state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (sts.more_seg) begin
          cmd.op     = OP_RD_LEN;
          state_next = S_WALK_CHK;
        end else begin
          cmd.op     = OP_RD_END;
          state_next = S_END;
        end
      end
      S_WALK_CHK: begin
        cmd.op     = OP_WALK;
        state_next = sts.reached ? S_RD_B : S_WALK_RD;
      end
      S_RD_B: begin
        cmd.op     = OP_RD_A;
        state_next = S_GET_B;
      end
      S_GET_B: begin
        cmd.op     = OP_GET_B;
        lax_next   = '0;
        state_next = S_LMUL;
      end
      S_LMUL: begin
        cmd.op     = OP_LMUL;
        cmd.axis   = lax;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.op     = OP_DINIT;
        cmd.axis   = lax;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DSTEP;
        cmd.axis = lax;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd32) begin
          state_next = S_LFIN;
        end
      end
      S_LFIN: begin
        cmd.op   = OP_LFIN;
        cmd.axis = lax;
        if (lax == 2'd2) begin
          cnt_next   = '0;
          state_next = S_JSQ;
        end else begin
          lax_next   = lax + 2'd1;
          state_next = S_LMUL;
        end
      end
      S_TH: begin
        cmd.op     = OP_THSQ;
        state_next = S_JUDGE;
      end
      S_JUDGE: begin
        cmd.op     = OP_JUDGE;
        state_next = S_EMIT;
      end
      S_END: begin
        cmd.op     = OP_END;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      lax   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      lax   <= lax_next;
    end
  end

endmodule

[sv/polyline_path_follower.sv]
// Path follower over a center line built from left/right edge vertex pairs.
// Input stream (s_*): one request per item. s_tuser selects load (0) or
// advance (1). A load stores the vertex midpoint as the next center point and
// measures the segment it closes; an advance moves along the path by
// step_distance, wraps at the total length and reports the interpolated,
// jump-limited position. Every request yields exactly one result on m_*.
// Config: APB, register 0 at byte address 0 is jump_threshold (31 bits).
// A load of any point but the first takes a square root in 32 steps. An
// advance walks the segments one at a time, then runs three 33-step
// divisions, one per axis, in one shared divider; past the end it reports
// the last center point instead.
// Only one request is in work at a time; the next one can be accepted in
// the cycle after the result is loaded.
// s_tready is high when idle, even while a result sits in the output register.
// If the receiver stalls, the finished result waits in the output register
// and the next one holds in the block until that slot frees.
// Reset (rst, synchronous) empties the path, zeroes distance and last
// position, and reloads jump_threshold with 0.2 in path units.
module polyline_path_follower #(
  parameter int MAX_POINTS = ppf_pkg::DEF_MAX_POINTS,
  parameter int FRAC_BITS  = ppf_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // left_x, left_y, left_z, right_x, right_y, right_z, step_distance, pad
  input  logic [ppf_pkg::S_TDATA_W-1:0] s_tdata,
  // func
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pos_x, pos_y, pos_z, segment_index, travelled, pad
  output logic [ppf_pkg::M_TDATA_W-1:0] m_tdata,
  // smoothed, status
  output logic [ppf_pkg::M_TUSER_W-1:0] m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ppf_pkg::*;

  localparam logic [30:0] THRESH_RST = 31'((64'd1 << FRAC_BITS) / 64'd5);

  logic [30:0]        thresh;
  cmd_t               cmd;
  sts_t               sts;
  logic signed [31:0] in_left [3];
  logic signed [31:0] in_right [3];
  logic signed [31:0] out_pos [3];
  logic               out_smoothed;
  logic [7:0]         out_seg;
  logic [30:0]        out_trav;
  logic [1:0]         out_status;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {1'b0, thresh} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      thresh <= pwdata[30:0];
    end
  end

  // unpack input request
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_left[i]  = s_tdata[32*i +: 32];
      in_right[i] = s_tdata[96 + 32*i +: 32];
    end
  end

  ppf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppf_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (s_tuser),
    .in_left      (in_left),
    .in_right     (in_right),
    .in_step      (s_tdata[222:192]),
    .thresh       (thresh),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_pos      (out_pos),
    .out_smoothed (out_smoothed),
    .out_seg      (out_seg),
    .out_trav     (out_trav),
    .out_status   (out_status)
  );

  // pack result
  assign m_tdata = {1'b0, out_trav, out_seg, out_pos[2], out_pos[1], out_pos[0]};
  assign m_tuser = {out_status, out_smoothed};

endmodule

[sv/ppf_checker.sv]
module ppf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ppf_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [ppf_pkg::M_TUSER_W-1:0] m_tuser
);
  import ppf_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed under stall");

  // one request in work at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a request while busy");

  // halving only on a normal advance
  a_sm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_OK)
    else $error("smoothed flag with non-ok status");

  // rejected or empty requests report the origin
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:1] == ST_FULL || m_tuser[2:1] == ST_EMPTY)
      |-> m_tdata[95:0] == '0)
    else $error("nonzero position on full or empty result");

endmodule

bind polyline_path_follower ppf_checker u_ppf_checker (.*);

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppf_pkg::*;

  localparam int NPTS        = 256;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               sm;
    logic [7:0]         seg;
    logic [30:0]        trav;
    logic [1:0]         st;
  } pos_result_t;

  // path model plus queue of positions still owed by the block
  class path_scoreboard;
    logic signed [31:0] cx[NPTS], cy[NPTS], cz[NPTS];
    longint unsigned    seglen[NPTS];
    int unsigned        npts, cur;
    longint unsigned    total, travel, acc, thr;
    longint signed      lastx, lasty, lastz;
    pos_result_t        owed[$];
    int                 errors;

    function new();
      npts = 0; cur = 0; total = 0; travel = 0; acc = 0;
      lastx = 0; lasty = 0; lastz = 0;
      thr = 13107;
      errors = 0;
    endfunction

    // (a+b)/2 toward minus infinity
    function logic signed [31:0] halfway(longint signed a, longint signed b);
      longint signed s;
      s = a + b;
      return 32'(s >>> 1);
    endfunction

    function longint unsigned absval(longint signed d);
      return d < 0 ? longint'(-d) : longint'(d);
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned dist_sq(longint signed dx, longint signed dy,
                                      longint signed dz, output bit big);
      longint unsigned ax, ay, az;
      ax = absval(dx); ay = absval(dy); az = absval(dz);
      big = (ax >= 64'h8000_0000) || (ay >= 64'h8000_0000) || (az >= 64'h8000_0000);
      if (big) return 0;
      return ax * ax + ay * ay + az * az;
    endfunction

    function logic signed [31:0] blend(longint signed a, longint signed b,
                                       longint unsigned num, longint unsigned den);
      longint signed   d;
      longint unsigned q;
      if (den == 0 || num == 0) return 32'(a);
      if (num > den) num = den;
      d = b - a;
      q = absval(d) * num / den;
      return d < 0 ? 32'(a - longint'(q)) : 32'(a + longint'(q));
    endfunction

    function pos_result_t predict(bit func, logic [191:0] v, logic [30:0] step);
      pos_result_t     r;
      logic signed [31:0] ax, ay, az;
      longint unsigned s, len, d, num;
      bit              big;
      r = '0;
      if (func == FUNC_LOAD) begin
        if (npts >= NPTS) begin
          r.trav = 31'(travel);
          r.st   = ST_FULL;
          return r;
        end
        ax = halfway($signed(v[31:0]),   $signed(v[127:96]));
        ay = halfway($signed(v[63:32]),  $signed(v[159:128]));
        az = halfway($signed(v[95:64]),  $signed(v[191:160]));
        cx[npts] = ax; cy[npts] = ay; cz[npts] = az;
        if (npts == 0) begin
          lastx = ax; lasty = ay; lastz = az;
        end else begin
          s = dist_sq(longint'(ax) - cx[npts-1], longint'(ay) - cy[npts-1],
                      longint'(az) - cz[npts-1], big);
          len = big ? LEN_MAX : root_floor(s);
          if (len > LEN_MAX) len = LEN_MAX;
          seglen[npts-1] = len;
          total = total + len;
          if (total > LEN_MAX) total = LEN_MAX;
        end
        r.px = ax; r.py = ay; r.pz = az;
        r.seg  = 8'(npts);
        r.trav = 31'(travel);
        r.st   = ST_OK;
        npts++;
        return r;
      end
      if (npts == 0) begin
        r.seg  = 8'(cur);
        r.trav = 31'(travel);
        r.st   = ST_EMPTY;
        return r;
      end
      d = travel + step;
      if (d > LEN_MAX) d = LEN_MAX;
      if (d > total) begin
        d -= total;
        cur = 0;
        acc = 0;
      end
      travel = d;
      // walk forward to the segment holding the new distance
      while (cur + 1 < npts) begin
        len = seglen[cur];
        if (acc + len >= travel) begin
          num = travel > acc ? travel - acc : 0;
          ax = blend(cx[cur], cx[cur+1], num, len);
          ay = blend(cy[cur], cy[cur+1], num, len);
          az = blend(cz[cur], cz[cur+1], num, len);
          s = dist_sq(ax - lastx, ay - lasty, az - lastz, big);
          if (big || s > thr * thr) begin
            ax = halfway(lastx, ax);
            ay = halfway(lasty, ay);
            az = halfway(lastz, az);
            r.sm = 1'b1;
          end
          lastx = ax; lasty = ay; lastz = az;
          r.px = ax; r.py = ay; r.pz = az;
          r.seg  = 8'(cur);
          r.trav = 31'(travel);
          r.st   = ST_OK;
          return r;
        end
        acc += len;
        if (acc > ACC_MAX) acc = ACC_MAX;
        cur++;
      end
      r.px = cx[npts-1]; r.py = cy[npts-1]; r.pz = cz[npts-1];
      r.seg  = 8'(cur);
      r.trav = 31'(travel);
      r.st   = ST_PAST_END;
      return r;
    endfunction

    function void note_request(bit func, logic [191:0] v, logic [30:0] step);
      owed.insert(owed.size(), predict(func, v, step));
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(pos_result_t got);
      pos_result_t want;
      if (owed.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = owed.pop_front();
      if (got.px !== want.px) report($sformatf("pos_x %0d want %0d", got.px, want.px));
      if (got.py !== want.py) report($sformatf("pos_y %0d want %0d", got.py, want.py));
      if (got.pz !== want.pz) report($sformatf("pos_z %0d want %0d", got.pz, want.pz));
      if (got.sm !== want.sm) report($sformatf("smoothed %0b want %0b", got.sm, want.sm));
      if (got.seg !== want.seg) report($sformatf("segment %0d want %0d", got.seg, want.seg));
      if (got.trav !== want.trav)
        report($sformatf("travelled %0d want %0d", got.trav, want.trav));
      if (got.st !== want.st) report($sformatf("status %0d want %0d", got.st, want.st));
    endtask
  endclass

  logic                 clk, rst;
  logic                 s_tvalid, s_tready;
  logic [S_TDATA_W-1:0] s_tdata;  // lx, ly, lz, rx, ry, rz, step_distance, pad
  logic                 s_tuser;  // func
  logic                 m_tvalid, m_tready;
  logic [M_TDATA_W-1:0] m_tdata;  // pos_x, pos_y, pos_z, segment_index, travelled, pad
  logic [M_TUSER_W-1:0] m_tuser;  // smoothed, status
  logic                 psel, penable, pwrite, pready;
  logic [2:0]           paddr;
  logic [31:0]          pwdata, prdata;

  path_scoreboard sb;
  bit             no_idle;
  int             hold_cycles;
  int             cycles = 0;

  polyline_path_follower dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // timeout watch
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("polyline_path_follower regression: fail");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result({m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0],
                       m_tdata[103:96], m_tdata[134:104], m_tuser[2:1]});
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else if (no_idle) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 35);
      end
    end
  end

  task send(bit func, logic [191:0] v, logic [30:0] step);
    int gap;
    gap = (!no_idle && $urandom_range(0, 99) < 35) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {1'b0, step, v};
    do @(posedge clk); while (!s_tready);
    sb.note_request(func, v, step);
  endtask

  task send_load(logic signed [31:0] lx, ly, lz, rx, ry, rz);
    send(FUNC_LOAD, {rz, ry, rx, lz, ly, lx}, '0);
  endtask

  task send_advance(logic [30:0] step);
    send(FUNC_ADVANCE, {6{32'($urandom())}}, step);
  endtask

  task wait_idle();
    s_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_threshold(logic [30:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= '0; pwdata <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.thr = value;
  endtask

  function logic signed [31:0] small_coord();
    return $signed(32'($urandom_range(0, 1 << 23))) - (1 << 22);
  endfunction

  // one random request: load a center point or advance along the path
  task random_request(int load_pct, int wide_pct, int big_step_pct);
    logic signed [31:0] c[3], o[3];
    if ($urandom_range(0, 99) < load_pct) begin
      if ($urandom_range(0, 99) < wide_pct) begin
        send(FUNC_LOAD, {$urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom()}, '0);
      end else begin
        foreach (c[i]) begin
          c[i] = small_coord();
          o[i] = ($urandom_range(0, 9) == 0) ? 0 : small_coord();
        end
        send_load(c[0] + o[0], c[1] + o[1], c[2] + o[2],
                  c[0] - o[0], c[1] - o[1], c[2] - o[2]);
      end
    end else if ($urandom_range(0, 99) < big_step_pct) begin
      send_advance(31'($urandom()));
    end else begin
      send_advance(31'($urandom_range(0, 1 << 23)));
    end
  endtask

  initial begin
    sb = new();
    no_idle = 0;
    hold_cycles = 0;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty path, single point, extreme vertices, zero-length and
    // ordinary segments, step saturation and wrap
    send_advance(31'd0);
    send_advance(LEN_MAX);
    send_load(0, 0, 0, 0, 0, 0);
    send_advance(31'd5);
    send_load(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_load(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_advance(31'd1);
    send_load(32'sh0003_0000, 32'sh0004_0000, 0, 32'sh0003_0000, 32'sh0004_0000, 0);
    send_load(32'sh0003_0000, 32'sh0004_0000, 32'sh000C_0000,
              32'sh0003_0001, 32'sh0004_0000, 32'sh000C_0000);
    send_advance(31'h0001_0000);
    send_advance(31'h0000_8000);
    send_advance(31'h0004_0000);
    send_advance(LEN_MAX);
    send_advance(31'd0);
    send_advance(31'h0002_0000);
    wait_idle();

    // threshold zero: every move is halved; long receiver hold-off
    write_threshold('0);
    hold_cycles = 3000;
    repeat (350) random_request(25, 0, 3);
    wait_idle();

    // threshold at maximum, no idling on either side
    write_threshold(LEN_MAX);
    no_idle = 1;
    repeat (350) random_request(25, 0, 3);
    wait_idle();
    no_idle = 0;

    // random threshold, some wide vertex pairs
    write_threshold(31'($urandom_range(0, 1 << 20)));
    repeat (350) random_request(25, 15, 5);
    wait_idle();

    // reset threshold again, table full by now, large steps
    write_threshold(31'd13107);
    repeat (320) random_request(20, 20, 40);
    s_tvalid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (sb.errors == 0) begin
      $display("polyline_path_follower regression: pass");
    end else begin
      $display("polyline_path_follower regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ppf_pkg.sv
sv/ppf_ram.sv
sv/ppf_dp.sv
sv/ppf_ctrl.sv
sv/polyline_path_follower.sv
sv/ppf_checker.sv
test/tb.sv
